FILE: sv/rtt_pkg.sv
// ============================================================================
// rtt_pkg
// shared constants for the receive timestamp ring tracker
// ============================================================================
`default_nettype none

package rtt_pkg;

   // field widths
   localparam int unsigned TIME_W   = 63;
   localparam int unsigned CTR_W    = 64;
   localparam int unsigned LEN_W    = 13;
   localparam int unsigned IDX_W    = 24;
   localparam int unsigned RING_W   = 25;
   localparam int unsigned JIT_W    = 8;
   localparam int unsigned PRE_W    = 32;
   localparam int unsigned SEEN_W   = 33;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned CSR_A_W  = 2;

   // largest block length and the largest value the length field holds
   localparam int unsigned MAX_BLOCK_DEF = 4096;
   localparam int unsigned LEN_FIELD_MAX = 8191;

   // register indexes
   localparam logic [CSR_A_W-1:0] REG_RING_LENGTH   = 2'd0;
   localparam logic [CSR_A_W-1:0] REG_JITTER_WINDOW = 2'd1;
   localparam logic [CSR_A_W-1:0] REG_PRESTREAM     = 2'd2;
   localparam logic [CSR_A_W-1:0] REG_NOTIFY_PERIOD = 2'd3;

   // register reset values
   localparam logic [RING_W-1:0] RING_RESET   = 25'd65536;
   localparam logic [JIT_W-1:0]  JITTER_RESET = 8'd1;

   // ring length limits
   localparam logic [RING_W-1:0] RING_MIN = 25'd8;
   localparam logic [RING_W-1:0] RING_MAX = 25'd16777216;

   // samples seen saturates here
   localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

endpackage

`default_nettype wire

FILE: sv/rx_timestamp_ring_tracker.sv
// ============================================================================
// rx_timestamp_ring_tracker
// bit-serial sample counter tracking, ring index and publish/notify logic
// ============================================================================
// sequence: an accepted item passes the bit-serial subtract/add/compare/modulo
//   of the 64-bit datapath, a load step, the next-index modulo and a finish
//   step; a new item is taken only once the last result has been committed
// reset: synchronous, active high; registers return to their defaults and
//   the counter, samples seen, notify time and published time clear to zero
`default_nettype none

module rx_timestamp_ring_tracker
   import rtt_pkg::*;
#(
   parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input items
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [79:0]          req_tdata,   // first_sample_time, block_len
   // result items
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   output      logic [127:0]         rsp_tdata,   // write_index, wrap_count,
                                                  // next_index, published_time
   output      logic [2:0]           rsp_tuser,   // resynced, published, notify
   // configuration writes
   input  wire logic                 csr_we,
   input  wire logic [CSR_A_W-1:0]   csr_addr,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   // block length cap, the field itself cannot exceed 8191
   localparam logic [LEN_W-1:0] LEN_CAP = (MAX_BLOCK > LEN_FIELD_MAX) ?
                                          LEN_W'(LEN_FIELD_MAX) : LEN_W'(MAX_BLOCK);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN_A = 3'd1;   // serial subtract/add/compare/modulo pass
   localparam logic [2:0] ST_LOAD  = 3'd2;   // resync decision, next-index setup
   localparam logic [2:0] ST_RUN_B = 3'd3;   // next-index modulo
   localparam logic [2:0] ST_DONE  = 3'd4;   // commit and hand over the result

   localparam logic [5:0] LAST_A = 6'd63;
   localparam logic [5:0] LAST_B = 6'd24;

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   logic [2:0]          state_ff,   state_in;
   logic [5:0]          cnt_ff,     cnt_in;

   // configuration
   logic [RING_W-1:0]   ring_ff,    ring_in;
   logic [JIT_W-1:0]    jit_ff,     jit_in;
   logic [PRE_W-1:0]    pre_ff,     pre_in;
   logic [RING_W-1:0]   per_ff,     per_in;

   // tracker state
   logic [CTR_W-1:0]    ctr_ff,     ctr_in;
   logic [SEEN_W-1:0]   seen_ff,    seen_in;
   logic [CTR_W-1:0]    nnt_ff,     nnt_in;
   logic [CTR_W-1:0]    lpub_ff,    lpub_in;

   // serial working registers
   // c_* follows the kept counter, h_* the hardware time (resync candidate)
   logic [CTR_W-1:0]    c_lsb_ff,   c_lsb_in;   // lsb first, refills with counter+len
   logic [CTR_W-1:0]    h_lsb_ff,   h_lsb_in;   // lsb first, refills with time+len
   logic [CTR_W-1:0]    c_msb_ff,   c_msb_in;   // msb first into the modulo
   logic [CTR_W-1:0]    h_msb_ff,   h_msb_in;
   logic [CTR_W-1:0]    nnt_sh_ff,  nnt_sh_in;
   logic [CTR_W-1:0]    s2c_ff,     s2c_in;     // counter+len+period
   logic [CTR_W-1:0]    s2h_ff,     s2h_in;
   logic [RING_W-1:0]   per_sh_ff,  per_sh_in;
   logic [LEN_W-1:0]    len_sh_ff,  len_sh_in;
   logic [LEN_W-1:0]    len_ff,     len_in;
   logic                dcy_ff,     dcy_in;     // carry of counter - time
   logic                cc_ff,      cc_in;
   logic                ch_ff,      ch_in;
   logic                cc2_ff,     cc2_in;
   logic                ch2_ff,     ch2_in;
   logic                gec_ff,     gec_in;     // new counter >= notify time
   logic                geh_ff,     geh_in;
   logic [7:0]          dlo_ff,     dlo_in;     // low byte of the difference
   logic                hz_ff,      hz_in;      // upper difference bits all zero
   logic                ho_ff,      ho_in;      // upper difference bits all one
   logic [IDX_W-1:0]    rc_ff,      rc_in;      // counter mod ring
   logic [IDX_W-1:0]    rh_ff,      rh_in;      // time mod ring
   logic [IDX_W-1:0]    rk_ff,      rk_in;      // 2^64 mod ring
   logic [IDX_W-1:0]    rn_ff,      rn_in;      // next index remainder
   logic [RING_W-1:0]   v_ff,       v_in;
   logic                resync_ff,  resync_in;
   logic [IDX_W-1:0]    start_ff,   start_in;
   logic [LEN_W-1:0]    wrap_ff,    wrap_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [127:0]        rsp_data_ff,  rsp_data_in;
   logic [2:0]          rsp_user_ff,  rsp_user_in;

   // ------------------------------------------------------------------------
   // combinational helpers
   // ------------------------------------------------------------------------
   logic [RING_W-1:0]   ring_eff;
   logic [LEN_W-1:0]    req_len;
   logic [LEN_W-1:0]    req_len_lim;
   logic [TIME_W-1:0]   req_time;

   // serial bits
   logic                cb, hb, lb, pb, nb;
   logic                db, scb, shb, s2cb, s2hb;
   logic [RING_W-1:0]   tc, th, tk, tn;

   // load stage
   logic                in_window;
   logic                res_dec;
   logic [IDX_W-1:0]    start_dec;
   logic                ovf_dec;
   logic [8:0]          lo_sum;
   logic [25:0]         sl_sum;
   logic [25:0]         t_adj;
   logic [25:0]         v_full;

   // finish stage
   logic                commit;
   logic [CTR_W-1:0]    new_ctr;
   logic                ge_sel;
   logic [CTR_W-1:0]    s2_sel;
   logic [SEEN_W:0]     seen_sum;
   logic [SEEN_W-1:0]   seen_new;
   logic                pub;
   logic                note;
   logic [CTR_W-1:0]    lpub_new;

   assign req_time    = req_tdata[TIME_W-1:0];
   assign req_len     = req_tdata[TIME_W+LEN_W-1:TIME_W];
   assign req_len_lim = (req_len > LEN_CAP) ? LEN_CAP : req_len;

   // ring length clamped to its legal range
   always_comb begin
      if (ring_ff < RING_MIN) begin
         ring_eff = RING_MIN;
      end else if (ring_ff > RING_MAX) begin
         ring_eff = RING_MAX;
      end else begin
         ring_eff = ring_ff;
      end
   end

   // one bit of every serial operand per cycle
   assign cb = c_lsb_ff[0];
   assign hb = h_lsb_ff[0];
   assign lb = len_sh_ff[0];
   assign pb = per_sh_ff[0];
   assign nb = nnt_sh_ff[0];

   // counter - time as counter + ~time + 1
   assign db   = cb ^ ~hb ^ dcy_ff;
   assign scb  = cb ^ lb ^ cc_ff;
   assign shb  = hb ^ lb ^ ch_ff;
   assign s2cb = scb ^ pb ^ cc2_ff;
   assign s2hb = shb ^ pb ^ ch2_ff;

   // restoring modulo steps, one dividend bit each
   assign tc = {rc_ff, c_msb_ff[CTR_W-1]};
   assign th = {rh_ff, h_msb_ff[CTR_W-1]};
   assign tk = {rk_ff, 1'b0};
   assign tn = {rn_ff, v_ff[RING_W-1]};

   // jitter window: diff in [0, J] or diff in [2^64 - J, 2^64 - 1]
   assign lo_sum    = {1'b0, dlo_ff} + {1'b0, jit_ff};
   assign in_window = (hz_ff && (dlo_ff <= jit_ff)) || (ho_ff && lo_sum[8]);
   assign res_dec   = !in_window;
   assign start_dec = res_dec ? rh_ff : rc_ff;
   assign ovf_dec   = res_dec ? ch_ff : cc_ff;      // carry out of the 64-bit add

   // next index from the start index: subtract 2^64 mod ring on counter wrap
   assign sl_sum = {2'b00, start_dec} + {13'd0, len_ff};
   assign t_adj  = sl_sum - (ovf_dec ? {2'b00, rk_ff} : 26'd0);
   assign v_full = t_adj[25] ? (t_adj + {1'b0, ring_eff}) : t_adj;

   assign commit   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign new_ctr  = resync_ff ? h_lsb_ff : c_lsb_ff;
   assign ge_sel   = resync_ff ? geh_ff : gec_ff;
   assign s2_sel   = resync_ff ? s2h_ff : s2c_ff;
   assign seen_sum = {1'b0, seen_ff} + {{(SEEN_W+1-LEN_W){1'b0}}, len_ff};
   assign seen_new = seen_sum[SEEN_W] ? SEEN_MAX : seen_sum[SEEN_W-1:0];
   assign pub      = seen_new > {1'b0, pre_ff};
   assign note     = pub && ge_sel;
   assign lpub_new = pub ? new_ctr : lpub_ff;

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ring_in    = ring_ff;
      jit_in     = jit_ff;
      pre_in     = pre_ff;
      per_in     = per_ff;
      ctr_in     = ctr_ff;
      seen_in    = seen_ff;
      nnt_in     = nnt_ff;
      lpub_in    = lpub_ff;
      c_lsb_in   = c_lsb_ff;
      h_lsb_in   = h_lsb_ff;
      c_msb_in   = c_msb_ff;
      h_msb_in   = h_msb_ff;
      nnt_sh_in  = nnt_sh_ff;
      s2c_in     = s2c_ff;
      s2h_in     = s2h_ff;
      per_sh_in  = per_sh_ff;
      len_sh_in  = len_sh_ff;
      len_in     = len_ff;
      dcy_in     = dcy_ff;
      cc_in      = cc_ff;
      ch_in      = ch_ff;
      cc2_in     = cc2_ff;
      ch2_in     = ch2_ff;
      gec_in     = gec_ff;
      geh_in     = geh_ff;
      dlo_in     = dlo_ff;
      hz_in      = hz_ff;
      ho_in      = ho_ff;
      rc_in      = rc_ff;
      rh_in      = rh_ff;
      rk_in      = rk_ff;
      rn_in      = rn_ff;
      v_in       = v_ff;
      resync_in  = resync_ff;
      start_in   = start_ff;
      wrap_in    = wrap_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // register writes, only while idle; the user is bound to this, the block itself does not enforce it
      if (csr_we) begin
         case (csr_addr)
            REG_RING_LENGTH:   ring_in = csr_wdata[RING_W-1:0];
            REG_JITTER_WINDOW: jit_in  = csr_wdata[JIT_W-1:0];
            REG_PRESTREAM:     pre_in  = csr_wdata[PRE_W-1:0];
            REG_NOTIFY_PERIOD: per_in  = csr_wdata[RING_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // load the serial copies and seed the carries
               c_lsb_in  = ctr_ff;
               h_lsb_in  = {1'b0, req_time};
               c_msb_in  = ctr_ff;
               h_msb_in  = {1'b0, req_time};
               nnt_sh_in = nnt_ff;
               per_sh_in = per_ff;
               len_sh_in = req_len_lim;
               len_in    = req_len_lim;
               dcy_in    = 1'b1;
               cc_in     = 1'b0;
               ch_in     = 1'b0;
               cc2_in    = 1'b0;
               ch2_in    = 1'b0;
               gec_in    = 1'b1;
               geh_in    = 1'b1;
               hz_in     = 1'b1;
               ho_in     = 1'b1;
               rc_in     = '0;
               rh_in     = '0;
               rk_in     = IDX_W'(1);
               cnt_in    = '0;
               state_in  = ST_RUN_A;
            end
         end

         ST_RUN_A: begin
            // difference, its low byte and the upper-bit flags
            dcy_in = (cb & ~hb) | (dcy_ff & (cb ^ ~hb));
            if (cnt_ff < 6'd8) begin
               dlo_in = {db, dlo_ff[7:1]};
            end else begin
               hz_in = hz_ff & ~db;
               ho_in = ho_ff & db;
            end

            // both candidates advanced by the block length, refilled in place
            cc_in    = (cb & lb) | (cc_ff & (cb ^ lb));
            ch_in    = (hb & lb) | (ch_ff & (hb ^ lb));
            c_lsb_in = {scb, c_lsb_ff[CTR_W-1:1]};
            h_lsb_in = {shb, h_lsb_ff[CTR_W-1:1]};

            // candidate notify times
            cc2_in = (scb & pb) | (cc2_ff & (scb ^ pb));
            ch2_in = (shb & pb) | (ch2_ff & (shb ^ pb));
            s2c_in = {s2cb, s2c_ff[CTR_W-1:1]};
            s2h_in = {s2hb, s2h_ff[CTR_W-1:1]};

            // unsigned compare, the highest differing bit decides
            if (scb != nb) begin
               gec_in = scb;
            end
            if (shb != nb) begin
               geh_in = shb;
            end

            len_sh_in = {1'b0, len_sh_ff[LEN_W-1:1]};
            per_sh_in = {1'b0, per_sh_ff[RING_W-1:1]};
            nnt_sh_in = {1'b0, nnt_sh_ff[CTR_W-1:1]};

            // modulo of both candidates and of 2^64
            c_msb_in = {c_msb_ff[CTR_W-2:0], 1'b0};
            h_msb_in = {h_msb_ff[CTR_W-2:0], 1'b0};
            rc_in = (tc >= ring_eff) ? IDX_W'(tc - ring_eff) : tc[IDX_W-1:0];
            rh_in = (th >= ring_eff) ? IDX_W'(th - ring_eff) : th[IDX_W-1:0];
            rk_in = (tk >= ring_eff) ? IDX_W'(tk - ring_eff) : tk[IDX_W-1:0];

            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == LAST_A) begin
               state_in = ST_LOAD;
            end
         end

         ST_LOAD: begin
            resync_in = res_dec;
            start_in  = start_dec;
            wrap_in   = (sl_sum > {1'b0, ring_eff}) ?
                        LEN_W'(sl_sum - {1'b0, ring_eff}) : '0;
            v_in      = v_full[RING_W-1:0];
            rn_in     = '0;
            cnt_in    = '0;
            state_in  = ST_RUN_B;
         end

         ST_RUN_B: begin
            v_in   = {v_ff[RING_W-2:0], 1'b0};
            rn_in  = (tn >= ring_eff) ? IDX_W'(tn - ring_eff) : tn[IDX_W-1:0];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == LAST_B) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (commit) begin
               ctr_in  = new_ctr;
               seen_in = seen_new;
               lpub_in = lpub_new;
               if (note) begin
                  nnt_in = s2_sel;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, lpub_new[TIME_W-1:0], rn_ff, wrap_ff, start_ff};
               rsp_user_in  = {note, pub, resync_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ring_ff      <= RING_RESET;
         jit_ff       <= JITTER_RESET;
         pre_ff       <= '0;
         per_ff       <= '0;
         ctr_ff       <= '0;
         seen_ff      <= '0;
         nnt_ff       <= '0;
         lpub_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ring_ff      <= ring_in;
         jit_ff       <= jit_in;
         pre_ff       <= pre_in;
         per_ff       <= per_in;
         ctr_ff       <= ctr_in;
         seen_ff      <= seen_in;
         nnt_ff       <= nnt_in;
         lpub_ff      <= lpub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      c_lsb_ff    <= c_lsb_in;
      h_lsb_ff    <= h_lsb_in;
      c_msb_ff    <= c_msb_in;
      h_msb_ff    <= h_msb_in;
      nnt_sh_ff   <= nnt_sh_in;
      s2c_ff      <= s2c_in;
      s2h_ff      <= s2h_in;
      per_sh_ff   <= per_sh_in;
      len_sh_ff   <= len_sh_in;
      len_ff      <= len_in;
      dcy_ff      <= dcy_in;
      cc_ff       <= cc_in;
      ch_ff       <= ch_in;
      cc2_ff      <= cc2_in;
      ch2_ff      <= ch2_in;
      gec_ff      <= gec_in;
      geh_ff      <= geh_in;
      dlo_ff      <= dlo_in;
      hz_ff       <= hz_in;
      ho_ff       <= ho_in;
      rc_ff       <= rc_in;
      rh_ff       <= rh_in;
      rk_ff       <= rk_in;
      rn_ff       <= rn_in;
      v_ff        <= v_in;
      resync_ff   <= resync_in;
      start_ff    <= start_in;
      wrap_ff     <= wrap_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // a new item can enter while the last result still waits in the output register
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// rx_timestamp_ring_tracker testbench
// Drives announced receive blocks into the tracker and checks every result
// item against an in-bench prediction of counter resync, ring indexes, wrap
// count, time publishing and notify flags, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import rtt_pkg::*;

   localparam int unsigned CLK_HALF     = 10;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned HOLD_CYCLES  = 400;     // long result-side stall
   localparam int unsigned DRAIN_CYCLES = 120;     // idle time after the final drain
   localparam int unsigned PHASE_ITEMS  = 240;
   localparam int unsigned NUM_PHASES   = 8;
   localparam bit [62:0]   TIME_MAX     = {63{1'b1}};

   // one expected result item
   typedef struct packed {
      bit        resynced;
      bit [23:0] write_index;
      bit [12:0] wrap_count;
      bit [23:0] next_index;
      bit        published;
      bit [62:0] published_time;
      bit        notify;
   } ring_result_type;

   // how the first sample time of a random block relates to the counter
   typedef enum {T_TRACK, T_EDGE, T_JUMP} time_kind_type;

   // -------------------------------------------------------------------------
   // ring tracker scoreboard: keeps its own counter state and register copies,
   // predicts one result per accepted block and checks results in order
   // -------------------------------------------------------------------------
   class ring_tracker_scoreboard;
      bit [24:0]       ring_reg;
      bit [7:0]        jitter_reg;
      bit [31:0]       prestream_reg;
      bit [24:0]       period_reg;
      bit [63:0]       counter;
      bit [63:0]       seen;
      bit [63:0]       notify_at;
      bit [63:0]       last_pub;
      ring_result_type ring_results_q[$];
      int              errors, n_blocks, n_checked, n_settings;
      int              n_resync, n_wrap, n_pub, n_notify;

      function void clear();
         ring_reg      = RING_RESET;
         jitter_reg    = JITTER_RESET;
         prestream_reg = '0;
         period_reg    = '0;
         counter       = '0;
         seen          = '0;
         notify_at     = '0;
         last_pub      = '0;
         ring_results_q.delete();
      endfunction

      function void set_reg(logic [CSR_A_W-1:0] idx, bit [31:0] v);
         case (idx)
            REG_RING_LENGTH:   ring_reg      = v[24:0];
            REG_JITTER_WINDOW: jitter_reg    = v[7:0];
            REG_PRESTREAM:     prestream_reg = v;
            REG_NOTIFY_PERIOD: period_reg    = v[24:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return ring_results_q.size();
      endfunction

      // note one accepted block and queue the result it must produce
      function void note_block(bit [62:0] t, bit [12:0] len_in);
         ring_result_type w;
         bit [63:0]       ring, len, diff, start, wrap;
         ring = 64'(ring_reg);
         if (ring < RING_MIN) ring = 64'(RING_MIN);
         if (ring > RING_MAX) ring = 64'(RING_MAX);
         len  = (len_in > MAX_BLOCK_DEF) ? 64'(MAX_BLOCK_DEF) : 64'(len_in);
         // two's complement distance, inside the window from either side
         diff = counter - {1'b0, t};
         w.resynced = !(diff <= jitter_reg || (64'd0 - diff) <= jitter_reg);
         if (w.resynced) counter = {1'b0, t};
         start = counter % ring;
         wrap  = (start + len > ring) ? start + len - ring : 64'd0;
         counter += len;
         w.write_index = start[23:0];
         w.wrap_count  = wrap[12:0];
         w.next_index  = 24'(counter % ring);
         seen += len;
         if (seen > SEEN_MAX) seen = 64'(SEEN_MAX);
         w.published = (seen > prestream_reg);
         w.notify    = 1'b0;
         if (w.published) begin
            last_pub = counter;
            if (counter >= notify_at) begin
               w.notify  = 1'b1;
               notify_at = counter + period_reg;
            end
         end
         w.published_time = last_pub[62:0];
         ring_results_q = {ring_results_q, w};
         n_blocks++;
         n_resync += w.resynced;
         n_wrap   += (wrap != 0);
         n_pub    += w.published;
         n_notify += w.notify;
      endfunction

      task report(string msg);
         $display("ERROR @%0t result %0d: %s", $realtime, n_checked, msg);
         errors++;
      endtask

      task check_result(logic [127:0] d, logic [2:0] u);
         ring_result_type w;
         if (ring_results_q.size() == 0) begin
            report("result item with no block waiting");
            return;
         end
         w = ring_results_q.pop_front();
         if (u[0] !== w.resynced)
            report($sformatf("resynced %b, want %b", u[0], w.resynced));
         if (d[23:0] !== w.write_index)
            report($sformatf("write_index %0h, want %0h", d[23:0], w.write_index));
         if (d[36:24] !== w.wrap_count)
            report($sformatf("wrap_count %0h, want %0h", d[36:24], w.wrap_count));
         if (d[60:37] !== w.next_index)
            report($sformatf("next_index %0h, want %0h", d[60:37], w.next_index));
         if (u[1] !== w.published)
            report($sformatf("published %b, want %b", u[1], w.published));
         if (d[123:61] !== w.published_time)
            report($sformatf("published_time %0h, want %0h", d[123:61], w.published_time));
         if (u[2] !== w.notify)
            report($sformatf("notify %b, want %b", u[2], w.notify));
         n_checked++;
      endtask
   endclass

   // dut signals
   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [79:0]         req_tdata;    // first_sample_time, block_len
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [127:0]        rsp_tdata;    // write_index, wrap_count, next_index, published_time
   logic [2:0]          rsp_tuser;    // resynced, published, notify
   logic                csr_we;
   logic [CSR_A_W-1:0]  csr_addr;
   logic [CSR_W-1:0]    csr_wdata;

   ring_tracker_scoreboard sb = new();

   bit no_idle  = 1'b0;   // both sides run without gaps while set
   bit hold_rsp = 1'b0;   // asks the result side for one long stall
   int cycles;

   rx_timestamp_ring_tracker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // run-away guard
   initial begin
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d results still due", cycles, sb.pending());
      $display("Simulation FAILED");
      $finish;
   end

   // cycles a side waits before its next item
   function automatic int pick_gap();
      return no_idle ? 0 : $urandom_range(0, 3);
   endfunction

   // present one block and hold it until the tracker takes it
   task automatic send_block(bit [62:0] t, bit [12:0] len);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, len, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_block(t, len);
   endtask

   // stop offering items and wait for every outstanding result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // write all four registers back to back, tracker idle
   task automatic configure(bit [31:0] ring, bit [31:0] jit, bit [31:0] pre,
                            bit [31:0] per);
      csr_we    <= 1'b1;
      csr_addr  <= REG_RING_LENGTH;
      csr_wdata <= ring;
      @(posedge clock);
      csr_addr  <= REG_JITTER_WINDOW;
      csr_wdata <= jit;
      @(posedge clock);
      csr_addr  <= REG_PRESTREAM;
      csr_wdata <= pre;
      @(posedge clock);
      csr_addr  <= REG_NOTIFY_PERIOD;
      csr_wdata <= per;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_reg(REG_RING_LENGTH, ring);
      sb.set_reg(REG_JITTER_WINDOW, jit);
      sb.set_reg(REG_PRESTREAM, pre);
      sb.set_reg(REG_NOTIFY_PERIOD, per);
      sb.n_settings++;
   endtask

   // first sample time relative to the predicted counter
   function automatic bit [62:0] make_time(time_kind_type kind);
      bit [63:0]   t64;
      int unsigned off, j;
      j = sb.jitter_reg;
      case (kind)
         T_TRACK: begin
            // anywhere inside the window, edges included
            off = $urandom_range(0, 2 * j);
            t64 = (off >= j) ? sb.counter + (off - j) : sb.counter - (j - off);
         end
         T_EDGE: begin
            // one sample outside the window
            t64 = $urandom_range(0, 1) ? sb.counter + j + 1 : sb.counter - j - 1;
         end
         default: begin
            t64 = {$urandom, $urandom};
            if ($urandom_range(0, 7) == 0) t64 = TIME_MAX - $urandom_range(0, 8192);
         end
      endcase
      return t64[62:0];
   endfunction

   // mostly realistic block sizes, a few over the limit and at the extremes
   function automatic bit [12:0] pick_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8)  return 13'($urandom_range(0, 8191));
      if (r < 12) return $urandom_range(0, 1) ? 13'd0 : 13'(MAX_BLOCK_DEF);
      return 13'($urandom_range(1, 600));
   endfunction

   task automatic random_block();
      int unsigned   r;
      time_kind_type kind;
      r = $urandom_range(0, 99);
      kind = (r < 84) ? T_TRACK : (r < 92) ? T_EDGE : T_JUMP;
      send_block(make_time(kind), pick_len());
   endtask

   // register setting for each random phase; prestream is set just above what
   // has been seen so far so that publishing starts partway through
   task automatic start_phase(int p);
      bit [31:0] ring, jit, pre, per;
      drain();
      case (p)
         0: begin ring = 8;          jit = 0;   per = 0;
                  pre = 32'(sb.seen + $urandom_range(0, 20000)); end
         1: begin ring = RING_MAX;   jit = 255; per = RING_MAX;
                  pre = 32'(sb.seen + $urandom_range(0, 20000)); end
         2: begin ring = 0;          jit = 1;   pre = '1; per = 1; end       // never publishes
         3: begin ring = 32'h1FFFFFF; jit = $urandom_range(0, 255); pre = 0;
                  per = 32'h1FFFFFF; end
         4: begin ring = $urandom_range(8, RING_MAX); jit = $urandom_range(0, 255);
                  pre = 32'(sb.seen + $urandom_range(0, 40000));
                  per = $urandom_range(0, 20000); end
         5: begin ring = 32768;      jit = 3;   pre = 0;  per = 5000; end
         6: begin ring = 1000;       jit = 0;   per = 0;
                  pre = 32'(sb.seen + $urandom_range(0, 20000)); end
         default: begin
                  ring = $urandom_range(0, 4096); jit = 255;
                  pre = 32'(sb.seen + $urandom_range(0, 60000));
                  per = $urandom_range(0, 3000); end
      endcase
      configure(ring, jit, pre, per);
   endtask

   // result side: random gaps, one long stall on request
   initial begin : rsp_side
      int gap;
      rsp_tready <= 1'b0;
      repeat (4) @(posedge clock);
      forever begin
         gap = pick_gap();
         if (hold_rsp) begin
            gap      = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // main sequence
   initial begin
      sb.clear();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= REG_RING_LENGTH;
      csr_wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed blocks at the reset register values
      send_block(63'd0, 13'd0);                           // all-zero fields
      send_block(63'd0, 13'(MAX_BLOCK_DEF));              // largest block, in step
      send_block(63'(sb.counter + 1), 13'd100);           // hw time one ahead
      send_block(63'(sb.counter - 1), 13'd1);             // hw time one behind
      send_block(63'(sb.counter + 2), 13'd50);            // just outside the window
      send_block(63'(sb.counter - 2), 13'd50);            // outside, other side
      send_block(63'(65536 - 10), 13'(MAX_BLOCK_DEF));    // spills past the ring end
      send_block(63'(sb.counter), 13'(MAX_BLOCK_DEF + 1)); // over-long, limited
      send_block(63'(sb.counter), 13'h1FFF);              // longest length field
      send_block(63'h5555_5555_5555_5555, 13'h0AAA);
      send_block(63'h2AAA_AAAA_AAAA_AAAA, 13'h1555);
      send_block(TIME_MAX, 13'(MAX_BLOCK_DEF));           // counter crosses bit 63
      send_block(TIME_MAX, 13'd10);
      send_block(63'(sb.counter), 13'd10);                // masked counter no longer matches
      send_block(63'd0, 13'd1);
      send_block(63'(65536 - 1), 13'd1);                  // ends exactly at ring end
      send_block(63'(sb.counter), 13'd2);                 // starts back at index zero

      // widest jitter window, smallest ring, short notify period
      drain();
      configure(8, 255, 0, 3);
      send_block(63'(sb.counter + 255), 13'd7);
      send_block(63'(sb.counter - 255), 13'd9);
      send_block(63'(sb.counter + 256), 13'd1);
      send_block(63'(sb.counter - 256), 13'd0);
      send_block(63'(sb.counter), 13'd3);
      send_block(63'(sb.counter), 13'd3);

      // random phases
      for (int p = 0; p < NUM_PHASES; p++) begin
         start_phase(p);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            no_idle = (p == 5) || (i % 60 >= 50);
            if (p == 4 && i == 60) hold_rsp = 1'b1;     // tracker fills and stalls input
            if (p == 6 && i == PHASE_ITEMS / 2) drain(); // sender waits for all results
            random_block();
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d of %0d blocks over %0d register settings, %0d resyncs, %0d wraps",
               sb.n_checked, sb.n_blocks, sb.n_settings, sb.n_resync, sb.n_wrap);
      $display("%0d blocks published time, %0d raised notify",
               sb.n_pub, sb.n_notify);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
